### rtl/tlw_pkg.sv
// tlw_pkg: shared types, constants and helpers of the text line wrapper
// used by every rtl file of the block but tlw_ifs; depends on nothing
`default_nettype none

package tlw_pkg;

	// widths sized for the largest supported line store (1024 columns)
	localparam int ADDR_LIM_W = 10;
	localparam int PTR_LIM_W  = 11;
	localparam int CNT_LIM_W  = 11;

	localparam int OUT_BYTES = 8;
	localparam int MIN_COLS  = 5;
	localparam int LEN_RESET = 80;

	localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
	localparam logic [7:0] SPACE_CHAR   = 8'h20;

	typedef enum logic [2:0] {
		CL_PLAIN,
		CL_SPACE,
		CL_PUNCT,
		CL_NEWLINE,
		CL_END
	} char_class_t;

	// emission request: bytes from the ring plus an optional newline
	typedef struct packed {
		logic [PTR_LIM_W-1:0] start;
		logic [CNT_LIM_W-1:0] len;
		logic                 add_nl;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
	} qstat_t;

	// oldest ring address the back end still has to read
	typedef struct packed {
		logic                 pending;
		logic [PTR_LIM_W-1:0] lo;
	} bstat_t;

	typedef struct packed {
		logic                  en;
		logic [ADDR_LIM_W-1:0] addr;
		logic [7:0]            data;
	} wr_t;

	// ! & * , - . / : ; = ? @ \ _
	function automatic logic is_break_punct(input logic [7:0] c);
		logic r;
		case (c) inside
			8'h21, 8'h26, 8'h2A, 8'h2C, 8'h2D, 8'h2E, 8'h2F,
			8'h3A, 8'h3B, 8'h3D, 8'h3F, 8'h40, 8'h5C, 8'h5F: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

### rtl/tlw_ifs.sv
// tlw_ifs: valid/ready channel interfaces of the text line wrapper
// input characters, packed output results and the line length write port
`default_nettype none

interface tlw_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       end_of_text;

	modport source (output valid, text_byte, end_of_text, input ready);
	modport sink (input valid, text_byte, end_of_text, output ready);
endinterface

interface tlw_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte0;
	logic [7:0] out_byte1;
	logic [7:0] out_byte2;
	logic [7:0] out_byte3;
	logic [7:0] out_byte4;
	logic [7:0] out_byte5;
	logic [7:0] out_byte6;
	logic [7:0] out_byte7;
	logic [3:0] byte_count;
	logic       last_of_run;

	modport source (output valid, out_byte0, out_byte1, out_byte2, out_byte3, out_byte4,
		out_byte5, out_byte6, out_byte7, byte_count, last_of_run, input ready);
	modport sink (input valid, out_byte0, out_byte1, out_byte2, out_byte3, out_byte4,
		out_byte5, out_byte6, out_byte7, byte_count, last_of_run, output ready);
endinterface

interface tlw_cfg_if;
	logic       valid;
	logic       ready;
	logic [8:0] line_length;

	modport source (output valid, line_length, input ready);
	modport sink (input valid, line_length, output ready);
endinterface

`default_nettype wire

### rtl/tlw_cmd_queue.sv
// tlw_cmd_queue: two-entry queue of emission requests between front and back
// depends on tlw_pkg
`default_nettype none

module tlw_cmd_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  tlw_pkg::cmd_t   push_cmd,
	input  logic            pop,
	output tlw_pkg::cmd_t   head,
	output tlw_pkg::qstat_t qstat
);

	tlw_pkg::cmd_t ent_q [2];
	logic          wp_q;
	logic          rp_q;
	logic [1:0]    cnt_q;

	assign head        = ent_q[rp_q];
	assign qstat.empty = (cnt_q == 2'd0);
	assign qstat.full  = (cnt_q == 2'd2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= push_cmd;
		end
	end

endmodule

`default_nettype wire

### rtl/tlw_front.sv
// tlw_front: accepts characters, writes them to the ring and decides line breaks
// depends on tlw_pkg and tlw_ifs
`default_nettype none

module tlw_front #(
	parameter int MAX_COLS = 256
) (
	input  logic            clk,
	input  logic            arst_n,
	tlw_in_if.sink          text_in,
	tlw_cfg_if.sink         cfg,
	input  tlw_pkg::qstat_t qstat,
	input  tlw_pkg::bstat_t bstat,
	output logic            cmd_push,
	output tlw_pkg::cmd_t   cmd,
	output tlw_pkg::wr_t    wr
);

	localparam int ADDR_W   = $clog2(MAX_COLS);
	localparam int PTR_W    = ADDR_W + 1;
	localparam int CNT_W    = $clog2(MAX_COLS + 1);
	localparam int LEN_INIT = (tlw_pkg::LEN_RESET > MAX_COLS) ? MAX_COLS : tlw_pkg::LEN_RESET;

	logic [PTR_W-1:0] head_q, head_n, wr_ptr, bound, lead;
	logic [CNT_W-1:0] fill_q, fill_n, fill_p, len_q, cfg_len;
	logic [CNT_W-1:0] sp_q, sp_n, pp_q, pp_n, cut, rest, emit_len;
	logic             sp_v_q, sp_v_n, pp_v_q, pp_v_n;
	logic             emit_nl, emit_req, accept, room, store_ok;
	tlw_pkg::char_class_t cls;

	// room check: the write must not land on bytes still queued for output
	assign wr_ptr        = head_q + PTR_W'(fill_q);
	assign bound         = bstat.pending ? bstat.lo[PTR_W-1:0] : head_q;
	assign lead          = wr_ptr - bound;
	assign room          = ~lead[PTR_W-1];
	assign text_in.ready = room & ~qstat.full;
	assign accept        = text_in.valid & text_in.ready;
	assign cfg.ready     = 1'b1;

	assign store_ok = (fill_q < CNT_W'(MAX_COLS));
	assign fill_p   = store_ok ? fill_q + CNT_W'(1) : fill_q;

	always_comb begin
		if (text_in.end_of_text) begin
			cls = tlw_pkg::CL_END;
		end else if (text_in.text_byte == tlw_pkg::NEWLINE_CHAR) begin
			cls = tlw_pkg::CL_NEWLINE;
		end else if (text_in.text_byte == tlw_pkg::SPACE_CHAR) begin
			cls = tlw_pkg::CL_SPACE;
		end else if (tlw_pkg::is_break_punct(text_in.text_byte)) begin
			cls = tlw_pkg::CL_PUNCT;
		end else begin
			cls = tlw_pkg::CL_PLAIN;
		end
	end

	always_comb begin
		head_n   = head_q;
		fill_n   = fill_p;
		sp_v_n   = sp_v_q;
		sp_n     = sp_q;
		pp_v_n   = pp_v_q;
		pp_n     = pp_q;
		emit_req = 1'b0;
		emit_len = '0;
		emit_nl  = 1'b0;
		cut      = '0;
		rest     = '0;
		unique case (cls)
			tlw_pkg::CL_END: begin
				emit_req = (fill_q != '0);
				emit_len = fill_q;
				head_n   = head_q + PTR_W'(fill_q);
				fill_n   = '0;
				sp_v_n   = 1'b0;
				pp_v_n   = 1'b0;
			end
			tlw_pkg::CL_NEWLINE: begin
				emit_req = 1'b1;
				emit_len = fill_p;
				head_n   = head_q + PTR_W'(fill_p);
				fill_n   = '0;
				sp_v_n   = 1'b0;
				pp_v_n   = 1'b0;
			end
			default: begin
				if (cls == tlw_pkg::CL_SPACE) begin
					sp_v_n = 1'b1;
					sp_n   = fill_q;
				end else if (cls == tlw_pkg::CL_PUNCT) begin
					pp_v_n = 1'b1;
					pp_n   = fill_q;
				end
				if (fill_p >= len_q) begin
					emit_req = 1'b1;
					emit_nl  = 1'b1;
					if (sp_v_n) begin
						// the space itself is dropped
						emit_len = sp_n;
						cut      = sp_n + CNT_W'(1);
					end else if (pp_v_n) begin
						cut      = pp_n + CNT_W'(1);
						emit_len = cut;
					end else begin
						cut      = fill_p;
						emit_len = fill_p;
					end
					rest   = (cut >= fill_p) ? '0 : fill_p - cut;
					head_n = head_q + PTR_W'(cut);
					fill_n = rest;
					if (sp_v_n && pp_v_n && pp_n >= cut && rest != '0) begin
						pp_n = pp_n - cut;
					end else begin
						pp_v_n = 1'b0;
					end
					sp_v_n = 1'b0;
				end
			end
		endcase
	end

	always_comb begin
		if (cfg.line_length < 9'(tlw_pkg::MIN_COLS)) begin
			cfg_len = CNT_W'(tlw_pkg::MIN_COLS);
		end else if ({23'b0, cfg.line_length} > 32'(MAX_COLS)) begin
			cfg_len = CNT_W'(MAX_COLS);
		end else begin
			cfg_len = CNT_W'(cfg.line_length);
		end
	end

	assign cmd_push    = accept & emit_req;
	assign cmd.start   = tlw_pkg::PTR_LIM_W'(head_q);
	assign cmd.len     = tlw_pkg::CNT_LIM_W'(emit_len);
	assign cmd.add_nl  = emit_nl;

	assign wr.en   = accept & (cls != tlw_pkg::CL_END) & store_ok;
	assign wr.addr = tlw_pkg::ADDR_LIM_W'(wr_ptr[ADDR_W-1:0]);
	assign wr.data = text_in.text_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			fill_q <= '0;
			sp_v_q <= 1'b0;
			sp_q   <= '0;
			pp_v_q <= 1'b0;
			pp_q   <= '0;
			len_q  <= CNT_W'(LEN_INIT);
		end else begin
			if (accept) begin
				head_q <= head_n;
				fill_q <= fill_n;
				sp_v_q <= sp_v_n;
				sp_q   <= sp_n;
				pp_v_q <= pp_v_n;
				pp_q   <= pp_n;
			end
			if (cfg.valid) begin
				len_q <= cfg_len;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/tlw_back.sv
// tlw_back: line ring memory, byte reader and result packer with output register
// depends on tlw_pkg and tlw_ifs
`default_nettype none

module tlw_back #(
	parameter int MAX_COLS         = 256,
	parameter int BYTES_PER_RESULT = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	tlw_out_if.source       text_out,
	input  tlw_pkg::qstat_t qstat,
	input  tlw_pkg::cmd_t   q_head,
	output logic            q_pop,
	input  tlw_pkg::wr_t    wr,
	output tlw_pkg::bstat_t bstat
);

	localparam int ADDR_W = $clog2(MAX_COLS);
	localparam int PTR_W  = ADDR_W + 1;
	localparam int CNT_W  = $clog2(MAX_COLS + 1);
	localparam int DEPTH  = 1 << ADDR_W;

	logic [7:0]       mem [DEPTH];
	logic             busy_q, nl_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] rem_q;
	logic             rv_s1, nl_s1, last_s1;
	logic [7:0]       rdata_s1, byte_s1;
	logic [7:0]       pack_q [tlw_pkg::OUT_BYTES];
	logic [3:0]       cnt_q, cnt_inc;
	logic             done_q, plast_q;
	logic [7:0]       out_b_q [tlw_pkg::OUT_BYTES];
	logic [3:0]       out_cnt_q;
	logic             out_last_q, out_v_q;
	logic             out_free, move, fill_done, done_next, issue, rd_mem, issue_last;

	assign out_free   = ~out_v_q | text_out.ready;
	assign move       = done_q & out_free;
	assign cnt_inc    = cnt_q + 4'd1;
	assign fill_done  = (cnt_inc == 4'(BYTES_PER_RESULT)) | last_s1;
	// a read is only issued when its byte can be packed in the next cycle
	assign done_next  = done_q ? ~move : (rv_s1 & fill_done);
	assign issue      = busy_q & ~done_next;
	assign q_pop      = ~busy_q & ~qstat.empty;
	assign rd_mem     = (rem_q != '0);
	assign issue_last = rd_mem ? ((rem_q == CNT_W'(1)) & ~nl_q) : 1'b1;
	assign byte_s1    = nl_s1 ? tlw_pkg::NEWLINE_CHAR : rdata_s1;

	assign bstat.pending = busy_q | ~qstat.empty;
	assign bstat.lo      = busy_q ? tlw_pkg::PTR_LIM_W'(rd_ptr_q) : q_head.start;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			nl_q     <= 1'b0;
			rd_ptr_q <= '0;
			rem_q    <= '0;
			rv_s1    <= 1'b0;
			nl_s1    <= 1'b0;
			last_s1  <= 1'b0;
		end else begin
			if (q_pop) begin
				busy_q   <= 1'b1;
				rd_ptr_q <= q_head.start[PTR_W-1:0];
				rem_q    <= q_head.len[CNT_W-1:0];
				nl_q     <= q_head.add_nl;
			end else if (issue) begin
				if (rd_mem) begin
					rd_ptr_q <= rd_ptr_q + PTR_W'(1);
					rem_q    <= rem_q - CNT_W'(1);
				end else begin
					nl_q <= 1'b0;
				end
				if (issue_last) begin
					busy_q <= 1'b0;
				end
			end
			rv_s1   <= issue;
			nl_s1   <= issue & ~rd_mem;
			last_s1 <= issue & issue_last;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr[ADDR_W-1:0]] <= wr.data;
		end
		if (issue && rd_mem) begin
			rdata_s1 <= mem[rd_ptr_q[ADDR_W-1:0]];
		end
	end

	// packer: unused slots stay zero so short results carry zero bytes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= 4'd0;
			done_q  <= 1'b0;
			plast_q <= 1'b0;
			out_v_q <= 1'b0;
			for (int i = 0; i < tlw_pkg::OUT_BYTES; i++) begin
				pack_q[i] <= 8'h00;
			end
		end else begin
			if (move) begin
				cnt_q  <= 4'd0;
				done_q <= 1'b0;
				for (int i = 0; i < tlw_pkg::OUT_BYTES; i++) begin
					pack_q[i] <= 8'h00;
				end
			end else if (rv_s1) begin
				pack_q[cnt_q[2:0]] <= byte_s1;
				cnt_q              <= cnt_inc;
				done_q             <= fill_done;
				plast_q            <= last_s1;
			end
			if (move) begin
				out_v_q <= 1'b1;
			end else if (text_out.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			out_b_q    <= pack_q;
			out_cnt_q  <= cnt_q;
			out_last_q <= plast_q;
		end
	end

	assign text_out.valid       = out_v_q;
	assign text_out.out_byte0   = out_b_q[0];
	assign text_out.out_byte1   = out_b_q[1];
	assign text_out.out_byte2   = out_b_q[2];
	assign text_out.out_byte3   = out_b_q[3];
	assign text_out.out_byte4   = out_b_q[4];
	assign text_out.out_byte5   = out_b_q[5];
	assign text_out.out_byte6   = out_b_q[6];
	assign text_out.out_byte7   = out_b_q[7];
	assign text_out.byte_count  = out_cnt_q;
	assign text_out.last_of_run = out_last_q;

endmodule

`default_nettype wire

### rtl/text_line_wrapper.sv
// text_line_wrapper: greedy word wrap top level; a character enters per cycle
// while the request queue has room and the ring has space. requests are queued,
// taken up by the reader, read byte by byte from the ring into rdata_s1, packed
// and moved to the output register; the back end moves one byte a cycle while
// results are taken, pausing after each result and to take up the next request.
// reset clears all line state, line length is min(80, MAX_COLS); no clearing pass
`default_nettype none

module text_line_wrapper #(
	parameter int MAX_COLS         = 256,
	parameter int BYTES_PER_RESULT = 8
) (
	input logic       clk,
	input logic       arst_n,
	tlw_cfg_if.sink   cfg,
	tlw_in_if.sink    text_in,
	tlw_out_if.source text_out
);

	// request channel between the front and the queue
	logic            cmd_push;
	tlw_pkg::cmd_t   cmd;

	// queue side seen by the back end
	tlw_pkg::cmd_t   q_head;
	logic            q_pop;
	tlw_pkg::qstat_t qstat;

	// ring write from the front, read progress reported by the back
	tlw_pkg::wr_t    wr;
	tlw_pkg::bstat_t bstat;

	// front: classifies each transaction, stores the byte, decides the break
	tlw_front #(
		.MAX_COLS (MAX_COLS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.text_in  (text_in),
		.cfg      (cfg),
		.qstat    (qstat),
		.bstat    (bstat),
		.cmd_push (cmd_push),
		.cmd      (cmd),
		.wr       (wr)
	);

	// short queue so the front keeps taking characters while a line drains
	tlw_cmd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (cmd_push),
		.push_cmd (cmd),
		.pop      (q_pop),
		.head     (q_head),
		.qstat    (qstat)
	);

	// back: reads the ring, appends the newline and packs the results
	tlw_back #(
		.MAX_COLS         (MAX_COLS),
		.BYTES_PER_RESULT (BYTES_PER_RESULT)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.text_out (text_out),
		.qstat    (qstat),
		.q_head   (q_head),
		.q_pop    (q_pop),
		.wr       (wr),
		.bstat    (bstat)
	);

endmodule

`default_nettype wire

### tb/text_line_wrapper_tb.sv
// text_line_wrapper_tb: self-checking bench for the greedy word wrapper
// holds its own line model, drives characters and line length writes, checks packed results
// depends on text_line_wrapper, tlw_pkg and the channel interfaces in tlw_ifs

module text_line_wrapper_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STORE_COLS = 256;
	localparam int CYCLE_LIMIT = 4_000_000;
	localparam int SETTLE_CYCLES = 24;
	localparam int LONG_HOLD = 300;
	localparam int MAX_REPORTS = 40;

	// characters after which a line may be broken
	localparam byte BREAK_SET [14] = '{"!", "&", "*", ",", "-", ".", "/", ":", ";", "=", "?",
		"@", "\\", "_"};

	typedef struct packed {
		logic [7:0] ch;
		logic       eot;
	} text_item_t;

	typedef struct packed {
		logic [7:0][7:0] chars;
		logic [3:0]      count;
		logic            last;
	} line_chunk_t;

	logic clk;
	logic arst_n;

	tlw_cfg_if cfg_if ();
	tlw_in_if  in_if ();
	tlw_out_if out_if ();

	text_line_wrapper #(
		.MAX_COLS(STORE_COLS),
		.BYTES_PER_RESULT(tlw_pkg::OUT_BYTES)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_if),
		.text_in(in_if),
		.text_out(out_if)
	);

	// pending characters and the chunks the model says must come out
	text_item_t  pending_chars [$];
	line_chunk_t expected_chunks [$];

	// line model state
	logic [7:0] line_buf [STORE_COLS];
	int         line_fill;
	int         line_cols;
	bit         space_seen;
	int         space_at;
	bit         punct_seen;
	int         punct_at;

	// bookkeeping
	int  cycle_count;
	int  mismatches;
	int  results_checked;
	int  chars_taken;
	int  space_breaks;
	int  punct_breaks;
	int  hard_breaks;
	int  newline_lines;
	int  flushes;
	int  settings_used;

	// idling controls, owned by the sequence and read by driver and receiver
	bit  in_gaps_on;
	bit  out_gaps_on;
	int  hold_requests;

	// driver and receiver private state
	bit         in_taken;
	int         in_gap_left;
	text_item_t next_item;
	int         out_gap_left;
	int         hold_left;
	int         holds_done;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// mostly no gap, sometimes a short gap, rarely a long pause
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 88)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic bit ends_on_break(input logic [7:0] ch);
		for (int k = 0; k < 14; k++)
			if (BREAK_SET[k] == ch)
				return 1'b1;
		return 1'b0;
	endfunction

	function automatic void forget_line();
		line_fill  = 0;
		space_seen = 1'b0;
		space_at   = 0;
		punct_seen = 1'b0;
		punct_at   = 0;
	endfunction

	// split the first n stored bytes (plus newline) into output chunks
	function automatic void queue_line(input int n, input bit add_nl);
		logic [7:0]  emit_q [$];
		line_chunk_t chunk;
		int          k;
		for (k = 0; k < n && k < STORE_COLS; k++)
			emit_q.push_back(line_buf[k]);
		if (add_nl)
			emit_q.push_back(tlw_pkg::NEWLINE_CHAR);
		while (emit_q.size() != 0) begin
			chunk = '0;
			for (k = 0; k < tlw_pkg::OUT_BYTES && emit_q.size() != 0; k++)
				chunk.chars[k] = emit_q.pop_front();
			chunk.count = 4'(k);
			chunk.last  = (emit_q.size() == 0);
			expected_chunks.push_back(chunk);
		end
	endfunction

	// move the unsent tail of the line to the front
	function automatic void shift_out(input int n);
		if (n >= line_fill) begin
			line_fill = 0;
			return;
		end
		for (int k = 0; k < line_fill - n; k++)
			line_buf[k] = line_buf[k + n];
		line_fill -= n;
	endfunction

	function automatic void predict_wrap(input text_item_t it);
		int pos;
		int cut;
		if (it.eot) begin
			if (line_fill != 0)
				flushes++;
			queue_line(line_fill, 1'b0);
			forget_line();
			return;
		end
		pos = line_fill;
		if (pos < STORE_COLS) begin
			line_buf[pos] = it.ch;
			line_fill     = pos + 1;
		end
		if (it.ch == tlw_pkg::NEWLINE_CHAR) begin
			newline_lines++;
			queue_line(line_fill, 1'b0);
			forget_line();
			return;
		end
		if (it.ch == tlw_pkg::SPACE_CHAR) begin
			space_seen = 1'b1;
			space_at   = pos;
		end else if (ends_on_break(it.ch)) begin
			punct_seen = 1'b1;
			punct_at   = pos;
		end
		if (line_fill >= line_cols) begin
			if (space_seen) begin
				// the space itself is dropped
				cut = space_at + 1;
				queue_line(space_at, 1'b1);
				shift_out(cut);
				if (punct_seen && punct_at >= cut && line_fill != 0)
					punct_at -= cut;
				else
					punct_seen = 1'b0;
				space_seen = 1'b0;
				space_breaks++;
			end else if (punct_seen) begin
				cut = punct_at + 1;
				queue_line(cut, 1'b1);
				shift_out(cut);
				punct_seen = 1'b0;
				punct_breaks++;
			end else begin
				queue_line(line_fill, 1'b1);
				forget_line();
				hard_breaks++;
			end
			if (line_fill == 0)
				forget_line();
		end
	endfunction

	task automatic report_mismatch(input string field, input int got, input int want);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("mismatch: %s on result %0d, got 0x%0h, expected 0x%0h", field,
				results_checked, got, want);
	endtask

	task automatic check_chunk();
		line_chunk_t got;
		line_chunk_t want;
		got.chars = {out_if.out_byte7, out_if.out_byte6, out_if.out_byte5, out_if.out_byte4,
			out_if.out_byte3, out_if.out_byte2, out_if.out_byte1, out_if.out_byte0};
		got.count = out_if.byte_count;
		got.last  = out_if.last_of_run;
		if (expected_chunks.size() == 0) begin
			report_mismatch("result with nothing expected", got.count, 0);
		end else begin
			want = expected_chunks.pop_front();
			for (int k = 0; k < tlw_pkg::OUT_BYTES; k++)
				if (got.chars[k] !== want.chars[k])
					report_mismatch($sformatf("out_byte%0d", k), got.chars[k], want.chars[k]);
			if (got.count !== want.count)
				report_mismatch("byte_count", got.count, want.count);
			if (got.last !== want.last)
				report_mismatch("last_of_run", got.last, want.last);
		end
		results_checked++;
	endtask

	// sampling at the rising edge: output transactions are checked, input
	// transactions are fed to the line model
	always @(posedge clk) begin
		cycle_count++;
		in_taken <= in_if.valid && in_if.ready;
		if (arst_n && out_if.valid && out_if.ready)
			check_chunk();
		if (arst_n && in_if.valid && in_if.ready) begin
			chars_taken++;
			predict_wrap('{ch: in_if.text_byte, eot: in_if.end_of_text});
		end
	end

	// character driver: moves on once the current transaction is taken
	always @(negedge clk) begin
		if (!arst_n) begin
			in_if.valid <= 1'b0;
		end else if (!in_if.valid || in_taken) begin
			if (in_gap_left > 0) begin
				in_if.valid <= 1'b0;
				in_gap_left--;
			end else if (pending_chars.size() != 0) begin
				next_item = pending_chars.pop_front();
				in_if.valid       <= 1'b1;
				in_if.text_byte   <= next_item.ch;
				in_if.end_of_text <= next_item.eot;
				in_gap_left = in_gaps_on ? pick_gap() : 0;
			end else begin
				in_if.valid <= 1'b0;
			end
		end
	end

	// result receiver: random stalls, plus a long hold-off when requested
	always @(negedge clk) begin
		if (!arst_n) begin
			out_if.ready <= 1'b0;
		end else if (hold_left > 0) begin
			out_if.ready <= 1'b0;
			hold_left--;
		end else if (hold_requests != holds_done) begin
			holds_done++;
			hold_left = LONG_HOLD - 1;
			out_if.ready <= 1'b0;
		end else if (out_gap_left > 0) begin
			out_if.ready <= 1'b0;
			out_gap_left--;
		end else begin
			out_if.ready <= 1'b1;
			out_gap_left = out_gaps_on ? pick_gap() : 0;
		end
	end

	task automatic push_char(input logic [7:0] c);
		pending_chars.push_back('{ch: c, eot: 1'b0});
	endtask

	task automatic push_end(input logic [7:0] c);
		pending_chars.push_back('{ch: c, eot: 1'b1});
	endtask

	task automatic push_text(input string s);
		for (int k = 0; k < s.len(); k++)
			push_char(s[k]);
	endtask

	// prose-like text: words of letters between separators, with some noise
	// bytes, the odd very long word and an occasional end of text
	task automatic push_prose(input int n);
		int word_left;
		int r;
		word_left = 0;
		repeat (n) begin
			if (word_left == 0) begin
				r = $urandom_range(0, 99);
				if (r < 65)
					push_char(tlw_pkg::SPACE_CHAR);
				else if (r < 80)
					push_char(BREAK_SET[$urandom_range(0, 13)]);
				else if (r < 88)
					push_char(tlw_pkg::NEWLINE_CHAR);
				else if (r < 91)
					push_end(8'($urandom_range(0, 255)));
				else
					push_char(8'($urandom_range(0, 255)));
				word_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 70)
					: $urandom_range(1, 8);
			end else begin
				if ($urandom_range(0, 7) == 0)
					push_char(8'($urandom_range(0, 255)));
				else
					push_char(8'("a" + $urandom_range(0, 25)));
				word_left--;
			end
		end
	endtask

	// wait until every character is in and every result is out, then let
	// the pipeline settle in case the last character caused no result
	task automatic wait_idle();
		while (pending_chars.size() != 0 || in_if.valid || expected_chunks.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_line_length(input logic [8:0] v);
		@(negedge clk);
		cfg_if.line_length <= v;
		cfg_if.valid       <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_if.ready);
		line_cols = (v < tlw_pkg::MIN_COLS) ? tlw_pkg::MIN_COLS :
			(v > STORE_COLS) ? STORE_COLS : int'(v);
		settings_used++;
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	// watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT)
			@(posedge clk);
		$display("FAILURE");
		$finish;
	end

	initial begin
		logic [8:0] phase_cols [6];
		phase_cols = '{9'd511, 9'd5, 9'd12, 9'd256, 9'd40, 9'd2};

		// every input known from time zero
		arst_n            = 1'b0;
		in_if.valid       = 1'b0;
		in_if.text_byte   = 8'h00;
		in_if.end_of_text = 1'b0;
		out_if.ready      = 1'b0;
		cfg_if.valid      = 1'b0;
		cfg_if.line_length = 9'd0;
		in_gaps_on        = 1'b1;
		out_gaps_on       = 1'b1;
		line_cols         = tlw_pkg::LEN_RESET;
		settings_used     = 1;
		forget_line();

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty flush, lone newline, zero and all-ones bytes, flush
		// whose ignored byte is a newline
		push_end(8'hFF);
		push_text("\n");
		push_char(8'h00);
		push_char(8'hFF);
		push_text("a");
		push_end(tlw_pkg::NEWLINE_CHAR);
		// partial line left in store, then length lowered to the minimum, equal to its fill
		push_text("wx yz");
		wait_idle();
		write_line_length(9'd0);
		// break at the older space, punctuation carried over
		push_text("!");
		// space as the last column empties the line
		push_text("p ");
		// break after punctuation, then a line with no break point
		push_text("cde,x");
		push_text("1234");
		push_text("q\n");

		// random phases, each ending with the sender paused until the block
		// has drained before the next length is written
		for (int ph = 0; ph < 6; ph++) begin
			wait_idle();
			write_line_length(phase_cols[ph]);
			in_gaps_on  = (ph % 3 != 1);
			out_gaps_on = (ph % 3 != 2);
			// a full-width word with no break point gives the longest run
			if (ph == 0)
				repeat (STORE_COLS) push_char(8'("A" + $urandom_range(0, 25)));
			push_prose(30);
			// receiver holds off while the sender keeps offering back to back
			if (ph % 3 == 1)
				hold_requests++;
		end
		wait_idle();

		if (expected_chunks.size() != 0)
			report_mismatch("results still expected at end", 0, expected_chunks.size());

		$display("run covered %0d characters over %0d line length settings, %0d results checked",
			chars_taken, settings_used, results_checked);
		$display("breaks: %0d at space, %0d at punctuation, %0d hard; %0d newlines, %0d flushes",
			space_breaks, punct_breaks, hard_breaks, newline_lines, flushes);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
